[hdl/jpeg_scan_bit_reader_defines.svh]
// Assertion macros for the JPEG scan bit reader
`ifndef JPEG_SCAN_BIT_READER_DEFINES_SVH
`define JPEG_SCAN_BIT_READER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define JSBR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define JSBR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/jsbr_pkg.sv]
// Shared types and constants for the JPEG scan bit reader
package jsbr_pkg;

	localparam int BUFFER_BITS_DEF   = 32;
	localparam int MAX_READ_BITS_DEF = 16;
	localparam int QUEUE_DEPTH       = 2;

	localparam int VALUE_W = 16;
	localparam int HELD_W  = 6;
	localparam int COUNT_W = 5;

	localparam logic [7:0] BYTE_FF     = 8'hFF;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;
	localparam logic [7:0] BYTE_RST_LO = 8'hD0;
	localparam logic [7:0] BYTE_RST_HI = 8'hD7;
	localparam logic [7:0] BYTE_EOI    = 8'hD9;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_ALIGN = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FF_HELD   = 3'd1,
		ST_STUFFED   = 3'd2,
		ST_RESTART   = 3'd3,
		ST_EOI       = 3'd4,
		ST_MARKER    = 3'd5,
		ST_UNDERFLOW = 3'd6,
		ST_OVERFLOW  = 3'd7
	} status_t;

	// Operations the back end carries out on the bit buffer
	typedef enum logic [2:0] {
		OP_NONE,
		OP_APPEND,
		OP_RESTART,
		OP_READ,
		OP_ALIGN
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [7:0]         data;    // byte to append, or marker code
		status_t            status;  // status on success
		logic [COUNT_W-1:0] cnt;     // saturated read length
	} entry_t;

endpackage

[hdl/jsbr_if.sv]
// Valid/ready channel interfaces for scan items and results
interface jsbr_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic [4:0] bit_count;

	modport source (output valid, output action, output data_byte, output bit_count,
		input ready);
	modport sink (input valid, input action, input data_byte, input bit_count,
		output ready);
endinterface

interface jsbr_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] value;
	logic [2:0]  status;
	logic [7:0]  marker_code;
	logic [5:0]  bits_held;

	modport source (output valid, output value, output status, output marker_code,
		output bits_held, input ready);
	modport sink (input valid, input value, input status, input marker_code,
		input bits_held, output ready);
endinterface

[hdl/jsbr_front.sv]
// Front end: accepts scan items, tracks a held 0xFF, classifies into queue entries
module jsbr_front #(
	parameter int MAX_READ_BITS = jsbr_pkg::MAX_READ_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	jsbr_item_if.sink        item,
	input  logic             q_full,
	output logic             q_push,
	output jsbr_pkg::entry_t q_entry
);

	logic ff_pending_q;
	logic accept;

	assign item.ready = !q_full;
	assign accept     = item.valid && item.ready;
	assign q_push     = accept;

	// every push leaves 0xFF held exactly when the pushed byte is 0xFF
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_pending_q <= 1'b0;
		end else if (accept && jsbr_pkg::action_t'(item.action) == jsbr_pkg::ACT_PUSH) begin
			ff_pending_q <= (item.data_byte == jsbr_pkg::BYTE_FF);
		end
	end

	always_comb begin
		q_entry.op     = jsbr_pkg::OP_NONE;
		q_entry.data   = 8'd0;
		q_entry.status = jsbr_pkg::ST_OK;
		q_entry.cnt    = '0;
		case (jsbr_pkg::action_t'(item.action))
			jsbr_pkg::ACT_PUSH: begin
				if (item.data_byte == jsbr_pkg::BYTE_FF) begin
					q_entry.status = jsbr_pkg::ST_FF_HELD;
				end else if (!ff_pending_q) begin
					q_entry.op   = jsbr_pkg::OP_APPEND;
					q_entry.data = item.data_byte;
				end else if (item.data_byte == jsbr_pkg::BYTE_ZERO) begin
					q_entry.op     = jsbr_pkg::OP_APPEND;
					q_entry.data   = jsbr_pkg::BYTE_FF;
					q_entry.status = jsbr_pkg::ST_STUFFED;
				end else if (item.data_byte >= jsbr_pkg::BYTE_RST_LO &&
					item.data_byte <= jsbr_pkg::BYTE_RST_HI) begin
					q_entry.op     = jsbr_pkg::OP_RESTART;
					q_entry.data   = item.data_byte;
					q_entry.status = jsbr_pkg::ST_RESTART;
				end else if (item.data_byte == jsbr_pkg::BYTE_EOI) begin
					q_entry.data   = item.data_byte;
					q_entry.status = jsbr_pkg::ST_EOI;
				end else begin
					q_entry.data   = item.data_byte;
					q_entry.status = jsbr_pkg::ST_MARKER;
				end
			end
			jsbr_pkg::ACT_READ: begin
				q_entry.op = jsbr_pkg::OP_READ;
				if (item.bit_count > jsbr_pkg::COUNT_W'(MAX_READ_BITS)) begin
					q_entry.cnt = jsbr_pkg::COUNT_W'(MAX_READ_BITS);
				end else begin
					q_entry.cnt = item.bit_count;
				end
			end
			jsbr_pkg::ACT_ALIGN: begin
				q_entry.op = jsbr_pkg::OP_ALIGN;
			end
			default: begin
				q_entry.op = jsbr_pkg::OP_NONE;
			end
		endcase
	end

endmodule

[hdl/jsbr_fifo.sv]
// Short queue of classified entries between front and back end
module jsbr_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsbr_pkg::entry_t wr_entry,
	input  logic             pop,
	output jsbr_pkg::entry_t rd_entry,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH = jsbr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	jsbr_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/jsbr_back.sv]
// Back end: bit buffer, restart config register and the result register
module jsbr_back #(
	parameter int BUFFER_BITS = jsbr_pkg::BUFFER_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_data,
	input  logic             q_empty,
	input  jsbr_pkg::entry_t q_entry,
	output logic             q_pop,
	jsbr_result_if.source    result
);

	localparam int CW = $clog2(BUFFER_BITS + 1);

	logic [BUFFER_BITS-1:0]       buf_q;
	logic [CW-1:0]                bits_q;
	logic                         restart_enable_q;

	logic                         res_valid_q;
	logic [jsbr_pkg::VALUE_W-1:0] value_q;
	jsbr_pkg::status_t            status_q;
	logic [7:0]                   marker_q;
	logic [jsbr_pkg::HELD_W-1:0]  held_q;

	logic [BUFFER_BITS-1:0]       buf_n;
	logic [CW-1:0]                bits_n;
	logic [CW-1:0]                rest;
	logic [CW-1:0]                cnt_ext;
	logic [BUFFER_BITS-1:0]       shifted;
	logic [jsbr_pkg::VALUE_W-1:0] value_n;
	jsbr_pkg::status_t            status_n;
	logic [7:0]                   marker_n;

	assign q_pop   = !q_empty && (!res_valid_q || result.ready);
	assign cnt_ext = CW'(q_entry.cnt);
	assign rest    = bits_q - cnt_ext;
	assign shifted = buf_q >> rest;

	// bits above the valid count are don't-care; reads mask them off
	always_comb begin
		buf_n    = buf_q;
		bits_n   = bits_q;
		value_n  = '0;
		status_n = q_entry.status;
		marker_n = 8'd0;
		case (q_entry.op)
			jsbr_pkg::OP_APPEND: begin
				if ({1'b0, bits_q} + (CW + 1)'(8) > (CW + 1)'(BUFFER_BITS)) begin
					status_n = jsbr_pkg::ST_OVERFLOW;
				end else begin
					buf_n  = {buf_q[BUFFER_BITS-9:0], q_entry.data};
					bits_n = bits_q + CW'(8);
				end
			end
			jsbr_pkg::OP_RESTART: begin
				marker_n = q_entry.data;
				if (restart_enable_q) begin
					bits_n = '0;
				end
			end
			jsbr_pkg::OP_READ: begin
				if (cnt_ext > bits_q) begin
					status_n = jsbr_pkg::ST_UNDERFLOW;
				end else begin
					value_n = shifted[jsbr_pkg::VALUE_W-1:0] &
						~({jsbr_pkg::VALUE_W{1'b1}} << q_entry.cnt);
					bits_n  = rest;
				end
			end
			jsbr_pkg::OP_ALIGN: begin
				bits_n = {bits_q[CW-1:3], 3'b000};
			end
			default: begin
				marker_n = q_entry.data;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q            <= '0;
			bits_q           <= '0;
			restart_enable_q <= 1'b1;
			res_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				restart_enable_q <= cfg_data;
			end
			if (q_pop) begin
				buf_q       <= buf_n;
				bits_q      <= bits_n;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			value_q  <= value_n;
			status_q <= status_n;
			marker_q <= marker_n;
			held_q   <= jsbr_pkg::HELD_W'(bits_n);
		end
	end

	assign result.valid       = res_valid_q;
	assign result.value       = value_q;
	assign result.status      = status_q;
	assign result.marker_code = marker_q;
	assign result.bits_held   = held_q;

endmodule

[hdl/jpeg_scan_bit_reader.sv]
// Top level of the JPEG scan bit reader
// Takes one item (push byte, read bits, align) per clock while the queue is not full and
// returns one result per item, in order. An accepted item is written into the queue, and
// its result is then registered in the back end's result register; sustained rate is one
// item per cycle while the result channel is ready. The front end classifies
// bytes and tracks a held 0xFF; a two-entry queue separates it from the back end so a
// stalled result channel backs up into the queue before the item channel stalls.
// The restart_enable register resets to 1 and is written through cfg_valid/cfg_data.
`include "jpeg_scan_bit_reader_defines.svh"

module jpeg_scan_bit_reader #(
	parameter int BUFFER_BITS   = jsbr_pkg::BUFFER_BITS_DEF,
	parameter int MAX_READ_BITS = jsbr_pkg::MAX_READ_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	jsbr_item_if.sink     item,
	jsbr_result_if.source result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	jsbr_pkg::entry_t wr_entry;
	jsbr_pkg::entry_t rd_entry;

	assign cfg_ready = 1'b1;

	jsbr_front #(
		.MAX_READ_BITS(MAX_READ_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_entry(wr_entry)
	);

	jsbr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_entry(wr_entry),
		.pop     (q_pop),
		.rd_entry(rd_entry),
		.full    (q_full),
		.empty   (q_empty)
	);

	jsbr_back #(
		.BUFFER_BITS(BUFFER_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.q_empty (q_empty),
		.q_entry (rd_entry),
		.q_pop   (q_pop),
		.result  (result)
	);

	// only a successful read carries data
	`JSBR_ASSERT_NOW(a_value_only_on_ok, result.valid && result.value != 16'd0, result.status == jsbr_pkg::ST_OK, "nonzero value with non-ok status")
	// a marker code appears only with a marker status
	`JSBR_ASSERT_NOW(a_marker_status, result.valid && result.marker_code != 8'd0, result.status == jsbr_pkg::ST_RESTART || result.status == jsbr_pkg::ST_EOI || result.status == jsbr_pkg::ST_MARKER, "marker code without marker status")
	// restart status always carries an RSTn code
	`JSBR_ASSERT_NOW(a_restart_code, result.valid && result.status == jsbr_pkg::ST_RESTART, result.marker_code >= jsbr_pkg::BYTE_RST_LO && result.marker_code <= jsbr_pkg::BYTE_RST_HI, "restart status with bad code")
	// queue full means a result is stalled
	`JSBR_ASSERT_NEXT(a_full_needs_stall, !item.ready, result.valid, "queue full without pending result")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the JPEG scan bit reader: directed and random scan streams
module tb_top;
	import jsbr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 60;
	localparam int PHASE_ITEMS    = 625;

	typedef struct packed {
		logic [15:0] value;
		status_t     status;
		logic [7:0]  marker;
		logic [5:0]  held;
	} scan_result_t;

	// Bit buffer predictor plus the queue of results it has worked out
	class scan_scoreboard;
		logic [63:0]  bit_buf;
		int unsigned  held_bits;
		bit           ff_held;
		bit           restart_flush;
		scan_result_t expected_q[$];
		int           errors;
		int           results_seen;
		int           status_hits[8];

		function new();
			bit_buf = '0;
			held_bits = 0;
			ff_held = 1'b0;
			restart_flush = 1'b1;
			errors = 0;
			results_seen = 0;
			foreach (status_hits[i])
				status_hits[i] = 0;
		endfunction

		function void set_restart(bit en);
			restart_flush = en;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [63:0] low_mask(int unsigned w);
			if (w >= 64)
				return '1;
			return (64'd1 << w) - 64'd1;
		endfunction

		function status_t append_byte(logic [7:0] b);
			if (held_bits + 8 > BUFFER_BITS_DEF)
				return ST_OVERFLOW;
			bit_buf = ((bit_buf << 8) | {56'd0, b}) & low_mask(held_bits + 8);
			held_bits += 8;
			return ST_OK;
		endfunction

		function void note_item(action_t act, logic [7:0] b, logic [4:0] cnt);
			scan_result_t res;
			int unsigned  n;
			int unsigned  rest;
			logic [63:0]  bits;

			res = '0;
			res.status = ST_OK;
			case (act)
				ACT_PUSH: begin
					if (!ff_held) begin
						if (b == BYTE_FF) begin
							ff_held = 1'b1;
							res.status = ST_FF_HELD;
						end else
							res.status = append_byte(b);
					end else if (b == BYTE_FF) begin
						// fill byte: keep waiting for the marker code
						res.status = ST_FF_HELD;
					end else begin
						ff_held = 1'b0;
						if (b == BYTE_ZERO) begin
							res.status = append_byte(BYTE_FF);
							if (res.status == ST_OK)
								res.status = ST_STUFFED;
						end else if (b >= BYTE_RST_LO && b <= BYTE_RST_HI) begin
							res.status = ST_RESTART;
							res.marker = b;
							if (restart_flush) begin
								bit_buf = '0;
								held_bits = 0;
							end
						end else if (b == BYTE_EOI) begin
							res.status = ST_EOI;
							res.marker = b;
						end else begin
							res.status = ST_MARKER;
							res.marker = b;
						end
					end
				end
				ACT_READ: begin
					n = cnt;
					if (n > MAX_READ_BITS_DEF)
						n = MAX_READ_BITS_DEF;
					if (n > held_bits)
						res.status = ST_UNDERFLOW;
					else begin
						rest = held_bits - n;
						bits = (rest < 64) ? ((bit_buf >> rest) & low_mask(n)) : 64'd0;
						res.value = bits[15:0];
						held_bits = rest;
						bit_buf &= low_mask(rest);
					end
				end
				ACT_ALIGN: begin
					held_bits -= held_bits & 7;
					bit_buf &= low_mask(held_bits);
				end
				default: ;
			endcase
			res.held = held_bits[5:0];
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [15:0] value, logic [2:0] status, logic [7:0] marker,
			logic [5:0] held);
			scan_result_t exp;

			results_seen++;
			status_hits[status]++;
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with nothing expected: value %h status %0d", $time,
					value, status);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			if (value !== exp.value) begin
				$display("%0t: value mismatch: expected %h, actual %h", $time, exp.value, value);
				errors++;
			end
			if (status !== exp.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d", $time, exp.status,
					status);
				errors++;
			end
			if (marker !== exp.marker) begin
				$display("%0t: marker_code mismatch: expected %h, actual %h", $time, exp.marker,
					marker);
				errors++;
			end
			if (held !== exp.held) begin
				$display("%0t: bits_held mismatch: expected %0d, actual %0d", $time, exp.held,
					held);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	jsbr_item_if   item_ch ();
	jsbr_result_if result_ch ();

	scan_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holds_asked   = 0;
	int holds_served  = 0;
	int items_sent    = 0;
	int input_stalls  = 0;
	int quiet_cycles  = 0;

	jpeg_scan_bit_reader i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Monitor: inputs go to the predictor, results are checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				sb.note_item(action_t'(item_ch.action), item_ch.data_byte, item_ch.bit_count);
			if (item_ch.valid && !item_ch.ready)
				input_stalls++;
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.value, result_ch.status, result_ch.marker_code,
					result_ch.bits_held);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
			|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: random stalls, plus long hold-offs on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served < holds_asked) begin
				holds_served++;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(action_t act, logic [7:0] b, logic [4:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.action    <= act;
		item_ch.data_byte <= b;
		item_ch.bit_count <= cnt;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic push_byte(logic [7:0] b);
		send_item(ACT_PUSH, b, 5'($urandom_range(31)));
	endtask

	task automatic read_bits(logic [4:0] cnt);
		send_item(ACT_READ, 8'($urandom_range(255)), cnt);
	endtask

	task automatic align_byte();
		send_item(ACT_ALIGN, 8'($urandom_range(255)), 5'($urandom_range(31)));
	endtask

	task automatic write_restart_enable(bit en);
		cfg_valid <= 1'b1;
		cfg_data  <= en;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_restart(en);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// One scan fragment: mostly real byte traffic with reads, some odd items
	task automatic random_fragment();
		int unsigned pick;
		int unsigned kind;

		pick = $urandom_range(99);
		if (pick < 38)
			push_byte(8'($urandom_range(255)));
		else if (pick < 48) begin
			push_byte(BYTE_FF);
			push_byte(BYTE_ZERO);
		end else if (pick < 57) begin
			push_byte(BYTE_FF);
			if (pick >= 54)
				repeat ($urandom_range(1, 3)) push_byte(BYTE_FF);
			kind = $urandom_range(2);
			if (kind == 0)
				push_byte(BYTE_RST_LO + 8'($urandom_range(7)));
			else if (kind == 1)
				push_byte(BYTE_EOI);
			else
				push_byte(8'($urandom_range(255)));
		end else if (pick < 90) begin
			if ($urandom_range(9) == 0)
				read_bits(5'($urandom_range(17, 31)));
			else
				read_bits(5'($urandom_range(16)));
		end else if (pick < 96)
			align_byte();
		else
			send_item(ACT_NONE, 8'($urandom_range(255)), 5'($urandom_range(31)));
	endtask

	initial begin
		int target;

		arst_n            <= 1'b0;
		cfg_valid         <= 1'b0;
		cfg_data          <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.action    <= ACT_NONE;
		item_ch.data_byte <= 8'd0;
		item_ch.bit_count <= 5'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty buffer, fill to the top, markers with flush at reset setting
		read_bits(5'd0);
		read_bits(5'd1);
		align_byte();
		send_item(ACT_NONE, 8'hFF, 5'h1F);
		push_byte(8'h00);
		push_byte(8'hA5);
		push_byte(BYTE_FF);
		push_byte(BYTE_ZERO);
		push_byte(8'h5A);
		push_byte(8'h3C);
		read_bits(5'h1F);
		read_bits(5'd3);
		align_byte();
		push_byte(BYTE_FF);
		push_byte(BYTE_FF);
		push_byte(8'hD3);
		push_byte(BYTE_FF);
		push_byte(BYTE_EOI);
		push_byte(BYTE_FF);
		push_byte(8'hC4);
		push_byte(8'h11);
		push_byte(8'h22);
		push_byte(8'h33);
		push_byte(8'h44);
		push_byte(BYTE_FF);
		push_byte(BYTE_ZERO);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			write_restart_enable(ph == 1);
			send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 61 : 0;
			recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 10 : 0;
			if (ph == 2)
				holds_asked++;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				random_fragment();
				if (ph == 2 && holds_asked < 2 && items_sent > target - PHASE_ITEMS / 2)
					holds_asked++;
			end
			wait_drained();
		end

		$display("Run covered %0d items, %0d results, restart flush on and off, %0d input stalls",
			items_sent, sb.results_seen, input_stalls);
		$display("Status mix: ok %0d ff %0d stuffed %0d rst %0d eoi %0d mrk %0d under %0d over %0d",
			sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3],
			sb.status_hits[4], sb.status_hits[5], sb.status_hits[6], sb.status_hits[7]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
